/* hw/rtl/taf_pkg.sv */
// Shared constants and the log2 mantissa table for the thermistor
// averaging and Fahrenheit conversion block. No dependencies.
package taf_pkg;

  localparam int DEPTH_DEF      = 8;
  localparam int SAMPLE_W       = 10;
  localparam int OHMS_W         = 17;
  localparam int TEMP_W         = 14;
  localparam int FRAC_BITS      = 16;
  localparam int SERIES_RESET   = 10180;
  localparam int TEMP_MIN       = -2048;
  localparam int TEMP_MAX       = 8191;
  localparam int TEMP_OFFSET_Q4 = 8320;
  localparam int TEMP_SLOPE_Q4  = 532;

  // log2(1 + i/16) in Q12 for i = 0 .. 16.
  function automatic logic [12:0] log2_frac(input logic [4:0] idx);
    logic [12:0] v;
    begin
      unique case (idx)
        5'd0:    v = 13'd0;
        5'd1:    v = 13'd358;
        5'd2:    v = 13'd696;
        5'd3:    v = 13'd1016;
        5'd4:    v = 13'd1319;
        5'd5:    v = 13'd1607;
        5'd6:    v = 13'd1882;
        5'd7:    v = 13'd2145;
        5'd8:    v = 13'd2396;
        5'd9:    v = 13'd2637;
        5'd10:   v = 13'd2869;
        5'd11:   v = 13'd3092;
        5'd12:   v = 13'd3307;
        5'd13:   v = 13'd3514;
        5'd14:   v = 13'd3715;
        5'd15:   v = 13'd3908;
        5'd16:   v = 13'd4096;
        default: v = 13'd0;
      endcase
      return v;
    end
  endfunction

endpackage

/* hw/rtl/thermistor_average_to_fahrenheit_top.sv */
// Top level of the thermistor averaging and Fahrenheit conversion block.
// Depends on taf_pkg.
//
// Each input word carries one 10-bit divider reading; the block keeps a moving
// sum over DEPTH samples, divides to get the thermistor resistance in Q16, takes
// log2 and returns the temperature in sixteenths of a degree F, saturated to
// -2048 .. 8191, with a no_reading flag when the sum is zero. One word is in
// flight at a time. The bit-serial restoring divider takes one quotient bit a
// cycle and the one-bit normalizing shifter then walks to the leading one. A
// zero sum skips the divider, the shifter and the log and goes straight to the
// output.
module thermistor_average_to_fahrenheit_top
  import taf_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_tvalid,
  output logic        cfg_tready,
  input  logic [23:0] cfg_tdata,   // [16:0] series_ohms
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,    // [9:0] adc_sample
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,   // [13:0] temp_f_q4
  output logic        out_tuser    // [0] no_reading
);

  localparam int AW = $clog2(DEPTH);
  localparam int SW = SAMPLE_W + AW;
  localparam int DW = SW + 1;
  localparam int MW = OHMS_W + SW;
  localparam int NW = MW + FRAC_BITS;
  localparam int CW = $clog2(NW);
  localparam int PW = $clog2(NW);
  localparam int LW = PW + 1 + 12;
  localparam int TW = LW + 16;
  localparam logic [DW-1:0] FULL_SCALE = DW'(1024 * DEPTH);
  localparam logic signed [TW-1:0] T_BIAS = TW'(TEMP_OFFSET_Q4 * 4096 + 2048);
  localparam logic signed [TW-1:0] T_SLOPE = TW'(TEMP_SLOPE_Q4);
  localparam logic signed [TW-1:0] T_HI = TW'(TEMP_MAX);
  localparam logic signed [TW-1:0] T_LO = TW'(TEMP_MIN);

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_SUM  = 8'b0000_0010,
    S_MUL  = 8'b0000_0100,
    S_DIV  = 8'b0000_1000,
    S_NORM = 8'b0001_0000,
    S_LOG  = 8'b0010_0000,
    S_TEMP = 8'b0100_0000,
    S_DONE = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;

  logic [OHMS_W-1:0]   series_r;
  logic [SAMPLE_W-1:0] ring_mem [DEPTH];
  logic [DEPTH-1:0]    ring_vld_r;
  logic [SAMPLE_W-1:0] rd_r;
  logic                rd_ok_r;
  logic [SAMPLE_W-1:0] sample_r;
  logic [AW-1:0]       slot_r;
  logic [SW-1:0]       sum_r, sum_nxt;
  logic [DW-1:0]       den_r;
  logic [DW-1:0]       rem_r, rem_nxt;
  logic [NW-1:0]       quo_r, quo_nxt;
  logic [CW-1:0]       cnt_r;
  logic [PW-1:0]       pos_r;
  logic signed [LW-1:0] l_r;
  logic [TEMP_W-1:0]   res_temp_r;
  logic                res_nr_r;
  logic                out_tvalid_r;
  logic [TEMP_W-1:0]   out_temp_r;
  logic                out_nr_r;

  logic                in_acc;
  logic                ring_we;
  logic [MW-1:0]       num_w;
  logic [DW:0]         trial_w;
  logic                ge_w;
  logic [3:0]          idx_w;
  logic [7:0]          mrem_w;
  logic [12:0]         lo_w, hi_w, diff_w;
  logic [16:0]         iprod_w;
  logic [12:0]         frac_w;
  logic signed [PW:0]  exp_w;
  logic signed [LW-1:0] l_nxt;
  logic signed [TW-1:0] t_w, tq_w, tc_w;
  logic [SAMPLE_W-1:0] old_w;

  assign cfg_tready = 1'b1;
  assign in_tready  = (state_r == S_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign ring_we    = (state_r == S_SUM);

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {{(16 - TEMP_W){1'b0}}, out_temp_r};
  assign out_tuser  = out_nr_r;

  assign old_w   = rd_ok_r ? rd_r : '0;
  assign sum_nxt = sum_r - SW'(old_w) + SW'(sample_r);
  assign num_w   = {{SW{1'b0}}, series_r} * {{OHMS_W{1'b0}}, sum_r};

  assign trial_w = {rem_r, quo_r[NW-1]};
  assign ge_w    = (trial_w >= {1'b0, den_r});
  assign rem_nxt = ge_w ? DW'(trial_w - {1'b0, den_r}) : trial_w[DW-1:0];
  assign quo_nxt = {quo_r[NW-2:0], ge_w};

  assign idx_w   = quo_r[NW-2 -: 4];
  assign mrem_w  = quo_r[NW-6 -: 8];
  assign lo_w    = log2_frac({1'b0, idx_w});
  assign hi_w    = log2_frac(5'({1'b0, idx_w}) + 5'd1);
  assign diff_w  = hi_w - lo_w;
  assign iprod_w = diff_w[8:0] * {1'b0, mrem_w};
  assign frac_w  = lo_w + {4'b0, iprod_w[16:8]};
  assign exp_w   = $signed({1'b0, pos_r}) - (PW + 1)'(16);
  assign l_nxt   = $signed({exp_w, 12'b0}) + $signed({{(LW - 13){1'b0}}, frac_w});

  assign t_w  = T_BIAS - TW'(l_r) * T_SLOPE;
  assign tq_w = t_w >>> 12;
  always_comb begin
    priority if (tq_w > T_HI) begin
      tc_w = T_HI;
    end else if (tq_w < T_LO) begin
      tc_w = T_LO;
    end else begin
      tc_w = tq_w;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_acc) state_nxt = S_SUM;
      S_SUM:  state_nxt = S_MUL;
      S_MUL:  state_nxt = (sum_r == '0) ? S_DONE : S_DIV;
      S_DIV:  if (cnt_r == '0) state_nxt = S_NORM;
      S_NORM: begin
        if (quo_r == '0) begin
          state_nxt = S_DONE;
        end else if (quo_r[NW-1]) begin
          state_nxt = S_LOG;
        end
      end
      S_LOG:  state_nxt = S_TEMP;
      S_TEMP: state_nxt = S_DONE;
      S_DONE: if (!out_tvalid_r || out_tready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ring_we) begin
      ring_mem[slot_r] <= sample_r;
    end
    if (in_acc) begin
      rd_r <= ring_mem[slot_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      series_r     <= OHMS_W'(SERIES_RESET);
      ring_vld_r   <= '0;
      slot_r       <= '0;
      sum_r        <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_tvalid && cfg_tready) begin
        series_r <= cfg_tdata[OHMS_W-1:0];
      end
      if (ring_we) begin
        ring_vld_r[slot_r] <= 1'b1;
        sum_r              <= sum_nxt;
        slot_r             <= (slot_r == AW'(DEPTH - 1)) ? '0 : slot_r + AW'(1);
      end
      if (state_r == S_DONE && (!out_tvalid_r || out_tready)) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      sample_r <= in_tdata[SAMPLE_W-1:0];
      rd_ok_r  <= ring_vld_r[slot_r];
    end
    unique case (state_r)
      S_MUL: begin
        quo_r      <= {num_w, {FRAC_BITS{1'b0}}};
        den_r      <= FULL_SCALE - {1'b0, sum_r};
        rem_r      <= '0;
        cnt_r      <= CW'(NW - 1);
        pos_r      <= PW'(NW - 1);
        res_temp_r <= TEMP_W'(TEMP_MAX);
        res_nr_r   <= 1'b1;
      end
      S_DIV: begin
        quo_r    <= quo_nxt;
        rem_r    <= rem_nxt;
        cnt_r    <= cnt_r - CW'(1);
        res_nr_r <= 1'b0;
      end
      S_NORM: begin
        if (!quo_r[NW-1]) begin
          quo_r <= {quo_r[NW-2:0], 1'b0};
          pos_r <= pos_r - PW'(1);
        end
      end
      S_LOG: l_r <= l_nxt;
      S_TEMP: res_temp_r <= tc_w[TEMP_W-1:0];
      S_DONE: begin
        if (!out_tvalid_r || out_tready) begin
          out_temp_r <= res_temp_r;
          out_nr_r   <= res_nr_r;
        end
      end
      default: ;
    endcase
  end

endmodule

/* hw/rtl/taf_checker.sv */
// Port-level checks for the thermistor averaging top level, bound to it below.
// Depends on taf_pkg.
module taf_checker
  import taf_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata,
  input logic        out_tuser
);

  // A missing reading always reports the high temperature limit.
  a_no_reading_max: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser) |-> (out_tdata[TEMP_W-1:0] == TEMP_W'(TEMP_MAX)))
    else $error("no_reading word without the high limit");

  // The block is not ready in the cycle after taking a word.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input ready right after an accepted word");

  // A new result only appears at the end of the work on a word.
  a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> !$past(in_tready))
    else $error("result appeared while the block was idle");

  // A stalled result word holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata) && $stable(out_tuser)))
    else $error("stalled result word changed");

endmodule

bind thermistor_average_to_fahrenheit_top taf_checker u_taf_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

/* verif/taf_reading_checker.sv */
`timescale 1ns / 1ps
// Checker for the thermistor averaging block: it watches the configuration, sample and
// reading channels, predicts each reading and compares it. Depends on taf_pkg.
module taf_reading_checker
  import taf_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_tvalid,
  input  logic        cfg_tready,
  input  logic [23:0] cfg_tdata,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [15:0] in_tdata,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [15:0] out_tdata,
  input  logic        out_tuser,
  output int          outstanding,
  output int          failures
);

  typedef struct packed {
    logic signed [TEMP_W-1:0] temp_q4;
    logic                     no_reading;
  } reading_t;

  reading_t    expected_readings[$];
  int unsigned ring[DEPTH];
  int unsigned slot;
  int unsigned sample_sum;
  int unsigned ohms;
  int          errors;

  function automatic int frac_q12(input int i);
    case (i)
      0:       return 0;
      1:       return 358;
      2:       return 696;
      3:       return 1016;
      4:       return 1319;
      5:       return 1607;
      6:       return 1882;
      7:       return 2145;
      8:       return 2396;
      9:       return 2637;
      10:      return 2869;
      11:      return 3092;
      12:      return 3307;
      13:      return 3514;
      14:      return 3715;
      15:      return 3908;
      default: return 4096;
    endcase
  endfunction

  // Base-2 log of a nonzero Q16 value, returned in Q12.
  function automatic longint log2_q12(input longint unsigned v);
    int              lead;
    longint unsigned mant;
    int              idx;
    int              rem;
    longint          frac;
    lead = 0;
    for (int b = 0; b < 64; b++) begin
      if (v[b]) lead = b;
    end
    if (lead >= 12) mant = v >> (lead - 12);
    else mant = v << (12 - lead);
    idx  = int'(mant[11:8]);
    rem  = int'(mant[7:0]);
    frac = frac_q12(idx) + ((frac_q12(idx + 1) - frac_q12(idx)) * rem) / 256;
    return longint'(lead - FRAC_BITS) * 4096 + frac;
  endfunction

  function automatic reading_t predict_reading(input int unsigned sum, input int unsigned r_ohms);
    reading_t        r;
    longint unsigned rt_q16;
    longint unsigned num;
    longint unsigned den;
    longint          t;
    r.no_reading = (sum == 0);
    r.temp_q4    = TEMP_W'(TEMP_MAX);
    if (sum != 0) begin
      num    = longint'(r_ohms) * sum;
      den    = longint'(1024 * DEPTH) - sum;
      rt_q16 = (num << FRAC_BITS) / den;
      if (rt_q16 != 0) begin
        t = longint'(TEMP_OFFSET_Q4) * 4096 - longint'(TEMP_SLOPE_Q4) * log2_q12(rt_q16) + 2048;
        t = t >>> 12;
        if (t > TEMP_MAX) t = TEMP_MAX;
        if (t < TEMP_MIN) t = TEMP_MIN;
        r.temp_q4 = TEMP_W'(t);
      end
    end
    return r;
  endfunction

  task automatic flag(input string msg);
    errors++;
    if (errors <= 10) $display("%0t: mismatch: %s", $time, msg);
  endtask

  always @(posedge clk) begin
    reading_t    want;
    int unsigned sample;
    if (!rst_n) begin
      for (int i = 0; i < DEPTH; i++) ring[i] = 0;
      slot       = 0;
      sample_sum = 0;
      ohms       = SERIES_RESET;
      errors     = 0;
      expected_readings.delete();
      outstanding <= 0;
      failures    <= 0;
    end else begin
      if (cfg_tvalid && cfg_tready) ohms = cfg_tdata[OHMS_W-1:0];
      if (out_tvalid && out_tready) begin
        if (expected_readings.size() == 0) begin
          flag($sformatf("reading temp %0d no_reading %0b with none expected",
                         $signed(out_tdata[TEMP_W-1:0]), out_tuser));
        end else begin
          want = expected_readings.pop_front();
          if (want.temp_q4 !== $signed(out_tdata[TEMP_W-1:0]) || want.no_reading !== out_tuser)
          begin
            flag($sformatf("expected temp %0d no_reading %0b, got temp %0d no_reading %0b",
                           want.temp_q4, want.no_reading,
                           $signed(out_tdata[TEMP_W-1:0]), out_tuser));
          end
        end
      end
      if (in_tvalid && in_tready) begin
        sample     = in_tdata[SAMPLE_W-1:0];
        sample_sum = sample_sum - ring[slot] + sample;
        ring[slot] = sample;
        slot       = (slot == DEPTH - 1) ? 0 : slot + 1;
        expected_readings.push_back(predict_reading(sample_sum, ohms));
      end
      outstanding <= expected_readings.size();
      failures    <= errors;
    end
  end

endmodule

/* verif/tb_thermistor_average_to_fahrenheit_top.sv */
`timescale 1ns / 1ps
// Testbench top for the thermistor averaging block: drives samples, resistor settings and
// reading back-pressure, and gives the verdict. Depends on taf_pkg and taf_reading_checker.
module tb_thermistor_average_to_fahrenheit_top;
  import taf_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int QUIET_OUT_FROM = 30000;
  localparam int QUIET_OUT_TO   = 45000;
  localparam int QUIET_IN_FROM  = 450;
  localparam int QUIET_IN_TO    = 650;

  logic        clk;
  logic        rst_n;
  logic        cfg_tvalid;
  logic        cfg_tready;
  logic [23:0] cfg_tdata;
  logic        in_tvalid;
  logic        in_tready;
  logic [15:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;
  logic        out_tuser;
  int          outstanding;
  int          failures;
  int          cycle_count  = 0;
  int          stall_cycles = 0;
  int          samples_sent = 0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  thermistor_average_to_fahrenheit_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_tvalid(cfg_tvalid),
    .cfg_tready(cfg_tready),
    .cfg_tdata (cfg_tdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  taf_reading_checker reading_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_tvalid (cfg_tvalid),
    .cfg_tready (cfg_tready),
    .cfg_tdata  (cfg_tdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .outstanding(outstanding),
    .failures   (failures)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    out_tready  <= (cycle_count >= QUIET_OUT_FROM && cycle_count < QUIET_OUT_TO) ||
                   ($urandom_range(99) >= 10);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_tvalid && cfg_tready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("[thermistor_average_to_fahrenheit_top] ERROR");
        $finish;
      end
    end
  end

  task automatic push_sample(input logic [SAMPLE_W-1:0] s, input bit pad);
    if (!(samples_sent >= QUIET_IN_FROM && samples_sent < QUIET_IN_TO) &&
        $urandom_range(99) < 10) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {(pad ? 6'($urandom_range(63)) : 6'd0), s};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    samples_sent++;
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic write_ohms(input logic [23:0] v);
    drain();
    cfg_tvalid <= 1'b1;
    cfg_tdata  <= v;
    @(posedge clk);
    while (!cfg_tready) @(posedge clk);
    cfg_tvalid <= 1'b0;
  endtask

  function automatic logic [SAMPLE_W-1:0] random_sample();
    int pick;
    pick = $urandom_range(99);
    if (pick < 8) return '0;
    if (pick < 16) return '1;
    if (pick < 30) return SAMPLE_W'($urandom_range(15));
    if (pick < 40) return SAMPLE_W'($urandom_range(1023, 1000));
    return SAMPLE_W'($urandom_range(1023));
  endfunction

  // Whole rings of zeros bring the sum back to zero now and then.
  task automatic run_random(input int count);
    int done;
    done = 0;
    while (done < count) begin
      if ($urandom_range(99) < 3) begin
        repeat (DEPTH_DEF) push_sample('0, 1'($urandom_range(1)));
        done += DEPTH_DEF;
      end else begin
        push_sample(random_sample(), $urandom_range(9) == 0);
        done++;
      end
      if (done == count / 2 && $urandom_range(1) == 0) drain();
    end
  endtask

  initial begin
    rst_n      = 1'b0;
    cfg_tvalid = 1'b0;
    cfg_tdata  = '0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    push_sample('0, 1'b0);
    push_sample('0, 1'b1);
    repeat (DEPTH_DEF) push_sample('1, 1'b0);
    repeat (DEPTH_DEF) push_sample('0, 1'b0);
    push_sample(10'd1, 1'b0);
    push_sample(10'd512, 1'b1);
    push_sample('1, 1'b1);
    write_ohms(24'd0);
    repeat (3) push_sample(10'd700, 1'b0);
    write_ohms(24'd1000);
    push_sample(10'd1, 1'b0);

    run_random(190);
    write_ohms(24'd100000);
    run_random(190);
    drain();
    run_random(190);
    write_ohms(24'hFFFFFF);
    run_random(190);
    write_ohms(24'($urandom_range(100000, 1000)));
    run_random(190);
    write_ohms(24'd0);
    run_random(40);
    write_ohms(24'(SERIES_RESET));
    run_random(150);

    drain();
    repeat (120) @(posedge clk);
    if (failures == 0 && outstanding == 0) begin
      $display("[thermistor_average_to_fahrenheit_top] OK");
    end else begin
      $display("[thermistor_average_to_fahrenheit_top] ERROR");
    end
    $finish;
  end

endmodule
